[rtl/arcp_pkg.sv]
// shared types, constants and codes of the address run to cidr prefix converter
package arcp_pkg;

    localparam int ADDR_W = 32;
    localparam int CNT_W  = ADDR_W + 1;
    localparam int LEN_W  = 6;

    localparam logic ACT_ADDRESS = 1'b0;
    localparam logic ACT_FLUSH   = 1'b1;

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    typedef struct packed
    {
        logic [CNT_W-1:0] size;
        logic [LEN_W-1:0] length;
        logic             done;
    } step_t;

endpackage

[rtl/arcp_size_unit.sv]
// step unit: picks the largest aligned block at the walk address that fits the count
module arcp_size_unit
    import arcp_pkg::*;
(
    input  logic [ADDR_W-1:0] walk_addr,
    input  logic [CNT_W-1:0]  count,
    output step_t             step
);

    logic [CNT_W-1:0] low_bit;
    logic [CNT_W-1:0] high_bit;
    logic [CNT_W-1:0] size;
    logic [LEN_W-1:0] exponent;

    // lowest set bit of the address, an all-zero address counts as fully aligned
    always_comb
    begin
        if (walk_addr == '0)
        begin
            low_bit = {1'b1, {ADDR_W{1'b0}}};
        end
        else
        begin
            low_bit = {1'b0, walk_addr & (~walk_addr + {{(ADDR_W-1){1'b0}}, 1'b1})};
        end
    end

    // highest set bit of the remaining count
    always_comb
    begin
        for (int i = 0; i < CNT_W; i++)
        begin
            high_bit[i] = count[i] & ~(|(count >> (i + 1)));
        end
    end

    assign size = (low_bit < high_bit) ? low_bit : high_bit;

    always_comb
    begin
        exponent = '0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (size[i])
            begin
                exponent = exponent | LEN_W'(i);
            end
        end
    end

    assign step.size   = size;
    assign step.length = LEN_W'(ADDR_W) - exponent;
    assign step.done   = (count == size);

endmodule

[rtl/address_run_to_cidr_prefixes.sv]
// top level: run tracking, prefix walk sequencer and output register
// An address that opens or extends a run is taken without a stall and gives no
// transaction on the output. An address that breaks the run, or a flush while a
// run is open, closes the run and emits its covering prefixes in ascending order,
// up to 62 of them, the final one marked by last. The input is stalled during
// the walk: the shared step unit settles each prefix in the compute state and the
// output register holds it in the emit state until the output takes it. A flush
// with no open run is taken without a stall and emits nothing.
module address_run_to_cidr_prefixes
    import arcp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              action,
    input  logic [ADDR_W-1:0] address,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ADDR_W-1:0] prefix_address,
    output logic [LEN_W-1:0]  prefix_length,
    output logic              last
);

    state_t            state_reg, state_next;
    logic              run_open_reg, run_open_next;
    logic [ADDR_W-1:0] run_start_reg, run_start_next;
    logic [ADDR_W-1:0] prev_reg, prev_next;
    logic [ADDR_W-1:0] walk_addr_reg, walk_addr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0] pfx_addr_reg, pfx_addr_next;
    logic [LEN_W-1:0]  pfx_len_reg, pfx_len_next;
    logic              last_reg, last_next;

    logic              in_acc;
    logic              out_acc;
    logic [ADDR_W-1:0] addr_diff;
    logic              extends_run;
    logic [CNT_W-1:0]  run_count;
    step_t             step;

    arcp_size_unit u_size
    (
        .walk_addr (walk_addr_reg),
        .count     (cnt_reg),
        .step      (step)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_acc  = out_valid && !out_stall;

    assign addr_diff   = address - prev_reg;
    assign extends_run = (addr_diff[ADDR_W-1:1] == '0);
    // number of addresses in the open run, all ones plus one for the full space
    assign run_count   = {1'b0, prev_reg - run_start_reg} + {{(CNT_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        state_next     = state_reg;
        run_open_next  = run_open_reg;
        run_start_next = run_start_reg;
        prev_next      = prev_reg;
        walk_addr_next = walk_addr_reg;
        cnt_next       = cnt_reg;
        size_next      = size_reg;
        pfx_addr_next  = pfx_addr_reg;
        pfx_len_next   = pfx_len_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (action == ACT_FLUSH)
                    begin
                        run_open_next = 1'b0;
                        if (run_open_reg)
                        begin
                            walk_addr_next = run_start_reg;
                            cnt_next       = run_count;
                            state_next     = ST_CALC;
                        end
                    end
                    else if (!run_open_reg)
                    begin
                        run_open_next  = 1'b1;
                        run_start_next = address;
                        prev_next      = address;
                    end
                    else if (extends_run)
                    begin
                        prev_next = address;
                    end
                    else
                    begin
                        walk_addr_next = run_start_reg;
                        cnt_next       = run_count;
                        run_start_next = address;
                        prev_next      = address;
                        state_next     = ST_CALC;
                    end
                end
            end
            ST_CALC:
            begin
                size_next     = step.size;
                pfx_addr_next = walk_addr_reg;
                pfx_len_next  = step.length;
                last_next     = step.done;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        walk_addr_next = walk_addr_reg + size_reg[ADDR_W-1:0];
                        cnt_next       = cnt_reg - size_reg;
                        state_next     = ST_CALC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_open_reg  <= 1'b0;
            run_start_reg <= '0;
            prev_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            run_open_reg  <= run_open_next;
            run_start_reg <= run_start_next;
            prev_reg      <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_addr_reg <= walk_addr_next;
        cnt_reg       <= cnt_next;
        size_reg      <= size_next;
        pfx_addr_reg  <= pfx_addr_next;
        pfx_len_reg   <= pfx_len_next;
        last_reg      <= last_next;
    end

    assign out_valid      = (state_reg == ST_EMIT);
    assign prefix_address = pfx_addr_reg;
    assign prefix_length  = pfx_len_reg;
    assign last           = last_reg;

    // a flush with nothing open gives no transaction
    a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && action == ACT_FLUSH && !run_open_reg |=> state_reg == ST_IDLE)
        else $error("flush without open run started a walk");

    // the final prefix hands control back to the input
    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && last |=> !in_stall && !out_valid)
        else $error("walk did not end after final prefix");

    // a walk never runs out of addresses before its final prefix
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CALC |-> cnt_reg != '0)
        else $error("prefix walk with empty count");

    // the chosen block is a single power of two no larger than the count
    a_size_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CALC |-> $onehot(step.size) && step.size <= cnt_reg)
        else $error("bad block size from step unit");

    // between two prefixes of one run the sequencer passes through the compute state
    a_calc_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !last |=> !out_valid && state_reg == ST_CALC)
        else $error("prefix not followed by compute cycle");

endmodule

[sim/address_run_to_cidr_prefixes_test.sv]
// self-checking testbench for the address run to cidr prefix converter
module address_run_to_cidr_prefixes_test;
    import arcp_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 200;
    localparam int MAX_REPORTS = 10;

    typedef struct packed
    {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  length;
        logic              last;
    } prefix_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              action = ACT_ADDRESS;
    logic [ADDR_W-1:0] address = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [ADDR_W-1:0] prefix_address;
    logic [LEN_W-1:0]  prefix_length;
    logic              last;

    // predictor state
    logic [ADDR_W-1:0] run_first;
    logic [ADDR_W-1:0] run_latest;
    logic              run_active;
    prefix_t           pending_prefixes[$];

    int items_sent = 0;
    int runs_closed = 0;
    int prefixes_checked = 0;
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;

    address_run_to_cidr_prefixes dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .address        (address),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .prefix_address (prefix_address),
        .prefix_length  (prefix_length),
        .last           (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // walk the closed run upward, one aligned block per prefix
    task automatic queue_run_prefixes();
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] left;
        logic [ADDR_W:0]   count;
        logic [ADDR_W:0]   block;
        int                tz;
        int                lg;
        int                bits;
        logic              done;
        prefix_t           p;
        base = run_first;
        left = run_latest - run_first;
        runs_closed++;
        do
        begin
            tz = 0;
            while (tz < ADDR_W && base[tz] == 1'b0)
                tz++;
            count = {1'b0, left} + 1'b1;
            lg = 0;
            while (lg < ADDR_W && (count >> (lg + 1)) != 0)
                lg++;
            bits = (tz < lg) ? tz : lg;
            block = 1;
            block = block << bits;
            if (bits >= ADDR_W)
                done = 1'b1;
            else
            begin
                done = ({1'b0, left} == block - 1'b1);
                if (!done)
                    left = left - block[ADDR_W-1:0];
            end
            p.base = base;
            p.length = LEN_W'(ADDR_W - bits);
            p.last = done;
            pending_prefixes.push_back(p);
            base = base + block[ADDR_W-1:0];
        end
        while (!done);
    endtask

    task automatic track_transaction(input logic act, input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] step;
        step = addr - run_latest;
        if (act == ACT_FLUSH)
        begin
            if (run_active)
                queue_run_prefixes();
            run_active = 1'b0;
        end
        else if (!run_active)
        begin
            run_first = addr;
            run_latest = addr;
            run_active = 1'b1;
        end
        else if (step <= 1)
            run_latest = addr;
        else
        begin
            queue_run_prefixes();
            run_first = addr;
            run_latest = addr;
        end
    endtask

    task automatic send_item(input logic act, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        address <= addr;
        // the payload holds while stalled, so an offered transaction is always taken
        track_transaction(act, addr);
        items_sent++;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    // mostly well-formed runs with random content, some noise and stray flushes
    task automatic send_random_runs(input int count);
        int                stop_at;
        int                len;
        int                pick;
        logic [ADDR_W-1:0] a;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                send_item(logic'($urandom_range(1)), $urandom);
            else if (pick == 1)
                send_item(ACT_FLUSH, $urandom);
            else
            begin
                a = $urandom;
                case ($urandom_range(3))
                    0: a = a & ~((32'd1 << $urandom_range(12)) - 1);
                    1: a = 32'hFFFF_FFF0 | a[3:0];
                    default: ;
                endcase
                len = $urandom_range(10);
                send_item(ACT_ADDRESS, a);
                repeat (len)
                begin
                    a = a + (($urandom_range(4) == 0) ? 0 : 1);
                    send_item(ACT_ADDRESS, a);
                end
                if ($urandom_range(1) == 1)
                    send_item(ACT_FLUSH, $urandom);
            end
        end
    endtask

    task automatic test_opening_and_empty_flush();
        send_item(ACT_FLUSH, $urandom);
        send_item(ACT_ADDRESS, 32'h0000_0000);
        send_item(ACT_ADDRESS, 32'h0000_0000);
        send_item(ACT_FLUSH, 32'hFFFF_FFFF);
        send_item(ACT_FLUSH, 32'h0000_0000);
    endtask

    task automatic test_field_extremes();
        send_item(ACT_ADDRESS, 32'hFFFF_FFFF);
        send_item(ACT_FLUSH, 32'h0000_0000);
        send_item(ACT_ADDRESS, 32'hAAAA_AAAA);
        send_item(ACT_ADDRESS, 32'hAAAA_AAAB);
        send_item(ACT_ADDRESS, 32'hAAAA_AAAC);
        send_item(ACT_ADDRESS, 32'hAAAA_AAAD);
        send_item(ACT_ADDRESS, 32'h5555_5555);
        // a step down and a step of two both break the run
        send_item(ACT_ADDRESS, 32'h5555_5554);
        send_item(ACT_ADDRESS, 32'h5555_5556);
        send_item(ACT_FLUSH, 32'h5555_5557);
    endtask

    task automatic test_wrap_across_top();
        send_item(ACT_ADDRESS, 32'hFFFF_FFFD);
        send_item(ACT_ADDRESS, 32'hFFFF_FFFE);
        send_item(ACT_ADDRESS, 32'hFFFF_FFFF);
        send_item(ACT_ADDRESS, 32'h0000_0000);
        send_item(ACT_ADDRESS, 32'h0000_0001);
        send_item(ACT_ADDRESS, 32'h0000_0002);
        send_item(ACT_FLUSH, 32'h0000_0003);
        send_item(ACT_ADDRESS, 32'hFFFF_FFFF);
        send_item(ACT_ADDRESS, 32'h0000_0000);
        send_item(ACT_ADDRESS, 32'h8000_0000);
    endtask

    task automatic test_long_runs();
        logic [ADDR_W-1:0] a;
        a = 32'h0A00_0003;
        send_item(ACT_ADDRESS, a);
        repeat (10)
        begin
            a = a + 1;
            send_item(ACT_ADDRESS, a);
        end
        send_item(ACT_FLUSH, '0);
        a = 32'hFFFF_FFF9;
        send_item(ACT_ADDRESS, a);
        repeat (11)
        begin
            a = a + 1;
            send_item(ACT_ADDRESS, a);
        end
        a = $urandom;
        send_item(ACT_ADDRESS, a);
        repeat (6)
        begin
            a = a + (($urandom_range(7) == 0) ? 0 : 1);
            send_item(ACT_ADDRESS, a);
        end
        send_item(ACT_ADDRESS, a + 5);
        send_item(ACT_FLUSH, '1);
    endtask

    task automatic test_random_phase(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= stall_pct;
        send_random_runs(6);
    endtask

    task automatic test_output_hold();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_requests <= hold_requests + 1;
        send_random_runs(10);
    endtask

    initial
    begin
        run_first = '0;
        run_latest = '0;
        run_active = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_opening_and_empty_flush();
        test_field_extremes();
        test_wrap_across_top();
        test_long_runs();
        test_random_phase(0, 0);
        test_random_phase(59, 0);
        test_random_phase(0, 59);
        test_random_phase(21, 21);
        test_output_hold();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        in_valid <= 1'b0;
        while (pending_prefixes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d input transactions closing %0d runs, %0d prefixes checked",
                 items_sent, runs_closed, prefixes_checked);
        $display("phases: directed cases, long runs, random idling and a long output hold");
        if (mismatches == 0 && pending_prefixes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // long output hold, counted down cycle by cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_prefix
        prefix_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_prefixes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected prefix %h/%0d last %b", prefix_address,
                             prefix_length, last);
            end
            else
            begin
                want = pending_prefixes.pop_front();
                prefixes_checked++;
                if (prefix_address !== want.base || prefix_length !== want.length
                    || last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("prefix mismatch: expected %h/%0d last %b, got %h/%0d last %b",
                                 want.base, want.length, want.last,
                                 prefix_address, prefix_length, last);
                end
            end
        end
    end

endmodule
